[src/iir_biquad_cascade_df1_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the biquad cascade
// Concurrent checks that vanish in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef IIR_BIQUAD_CASCADE_DF1_MACROS_SVH
`define IIR_BIQUAD_CASCADE_DF1_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define IBQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define IBQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IBQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define IBQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[src/ibq_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ibq_pkg
// Types, constants and rounding helpers of the biquad cascade.
// ---------------------------------------------------------------------------
package ibq_pkg;

  localparam int SECTIONS = 4;
  localparam int NCOEF    = 5;
  localparam int COEF_W   = 18;
  localparam int SIG_W    = 24;
  localparam int SMP_W    = 16;
  localparam int CIDX_W   = 5;
  localparam int ACT_W    = 3;
  localparam int PROD_W   = COEF_W + SIG_W;
  localparam int ACC_W    = PROD_W + 3;
  localparam int COEF_FRAC = 14;
  localparam int SIG_FRAC  = 8;
  localparam int CFG_AW   = 1;

  localparam int SEC_IW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int CNT_W  = ($clog2(SECTIONS + 1) > ACT_W) ? $clog2(SECTIONS + 1) : ACT_W;
  localparam int CMP_W  = ($clog2(NCOEF * SECTIONS + 1) > CIDX_W) ?
                          $clog2(NCOEF * SECTIONS + 1) : CIDX_W;

  localparam logic signed [ACC_W-1:0] SIG_MAX = ACC_W'((64'sd1 <<< (SIG_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SIG_MIN = -ACC_W'(64'sd1 <<< (SIG_W - 1));
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));
  localparam logic signed [SIG_W:0]   OUT_HALF = (SIG_W + 1)'(64'sd1 <<< (SIG_FRAC - 1));
  localparam logic signed [SIG_W:0]   OUT_MAX = (SIG_W + 1)'((64'sd1 <<< (SMP_W - 1)) - 1);
  localparam logic signed [SIG_W:0]   OUT_MIN = -(SIG_W + 1)'(64'sd1 <<< (SMP_W - 1));

  typedef enum logic [2:0] {
    SLOT_B0 = 3'd0,
    SLOT_B1 = 3'd1,
    SLOT_B2 = 3'd2,
    SLOT_A1 = 3'd3,
    SLOT_A2 = 3'd4
  } coef_slot_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_GAIN   = 1'b0,
    CFG_ACTIVE = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_FILTER = 1'b0,
    CMD_COEF   = 1'b1
  } cmd_e;

  // sample travelling between section cells
  typedef struct packed {
    logic                    valid;
    logic                    sat;
    logic signed [SIG_W-1:0] x;
  } link_t;

  // coefficient write into one cell
  typedef struct packed {
    logic                     we;
    coef_slot_e               slot;
    logic signed [COEF_W-1:0] value;
  } coef_wr_t;

  typedef struct packed {
    logic                    sat;
    logic signed [SIG_W-1:0] val;
  } sig_res_t;

  typedef struct packed {
    logic                    sat;
    logic signed [SMP_W-1:0] val;
  } out_res_t;

  // round half up to Q.8 and saturate to the signal range
  function automatic sig_res_t rnd_sat_sig(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    sig_res_t r;
    t = (v + ACC_HALF) >>> COEF_FRAC;
    r.sat = 1'b0;
    r.val = t[SIG_W-1:0];
    if (t > SIG_MAX) begin
      r.sat = 1'b1;
      r.val = SIG_MAX[SIG_W-1:0];
    end else if (t < SIG_MIN) begin
      r.sat = 1'b1;
      r.val = SIG_MIN[SIG_W-1:0];
    end
    return r;
  endfunction

  // round half up to an integer and saturate to the sample range
  function automatic out_res_t rnd_sat_out(input logic signed [SIG_W-1:0] x);
    logic signed [SIG_W:0] t;
    out_res_t r;
    t = ((SIG_W + 1)'(x) + OUT_HALF) >>> SIG_FRAC;
    r.sat = 1'b0;
    r.val = t[SMP_W-1:0];
    if (t > OUT_MAX) begin
      r.sat = 1'b1;
      r.val = OUT_MAX[SMP_W-1:0];
    end else if (t < OUT_MIN) begin
      r.sat = 1'b1;
      r.val = OUT_MIN[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

[src/iir_biquad_cascade_df1.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iir_biquad_cascade_df1
// Cascade of direct-form-I biquad sections with shared gain, fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries requests. tuser is the command: 0 filters the sample in
//   tdata, 1 writes one coefficient word (index section*5+slot, slots b0,
//   b1, b2, a1, a2). Coefficient writes return nothing.
//   m_axis returns one result per filter request: the 16-bit sample in
//   tdata and the saturation flag in tuser.
//   The config port (cfg_we_i, cfg_addr_i, cfg_wdata_i) sets the gain and
//   the number of active sections; write it only while the block is idle.
// Timing:
//   Each section cell is a four-stage pipeline (products, sum and round,
//   gain multiply, round). A filter request passes in turn through the
//   N active cells, N being the active section count; its result is
//   registered at the output. The next request waits until the previous
//   one is done; one cell works at a time, so the chain sets the rate.
// Reset and stall:
//   Reset clears all coefficients and delays, sets gain to 1.0 and four
//   sections. A stalled result waits in the output register; one more
//   result may finish into a skid register, after which requests hold.
// ---------------------------------------------------------------------------
`include "iir_biquad_cascade_df1_macros.svh"

module iir_biquad_cascade_df1
  import ibq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,  // sample[15:0], coef_index[20:16],
                                           // coef_value[38:21], zero pad [39]
  input  logic              s_axis_tuser,  // cmd
  // result channel
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,  // filtered[15:0]
  output logic              m_axis_tuser,  // saturated
  // configuration
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [COEF_W-1:0] cfg_wdata_i
);

  // unpack request
  cmd_e                     cmd;
  logic signed [SMP_W-1:0]  sample;
  logic [CIDX_W-1:0]        coef_index;
  logic signed [COEF_W-1:0] coef_value;

  assign cmd        = cmd_e'(s_axis_tuser);
  assign sample     = s_axis_tdata[SMP_W-1:0];
  assign coef_index = s_axis_tdata[SMP_W+CIDX_W-1:SMP_W];
  assign coef_value = s_axis_tdata[SMP_W+CIDX_W+COEF_W-1:SMP_W+CIDX_W];

  // configuration registers
  logic signed [COEF_W-1:0] gain_q;
  logic [ACT_W-1:0]         active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= COEF_W'(16384);
      active_q <= ACT_W'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_GAIN:   gain_q   <= cfg_wdata_i;
        CFG_ACTIVE: active_q <= cfg_wdata_i[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective section count: zero acts as one, clip to the chain length
  logic [CNT_W-1:0]  n_eff;
  logic [SEC_IW-1:0] last_idx;
  logic [CNT_W-1:0]  n_less;

  always_comb begin
    n_eff = CNT_W'(active_q);
    if (n_eff == '0) begin
      n_eff = CNT_W'(1);
    end else if (n_eff > CNT_W'(SECTIONS)) begin
      n_eff = CNT_W'(SECTIONS);
    end
    n_less   = n_eff - CNT_W'(1);
    last_idx = n_less[SEC_IW-1:0];
  end

  // handshake and busy tracking
  logic     busy_q;
  logic     skid_valid_q;
  out_res_t skid_q;
  logic     in_acc, flt_acc, coef_acc;
  link_t    link_in  [SECTIONS];
  link_t    link_out [SECTIONS];
  logic [SECTIONS-1:0] out_valids;
  link_t    done_link;
  logic     done;
  out_res_t fin;

  assign s_axis_tready = !busy_q && !skid_valid_q;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign flt_acc  = in_acc && (cmd == CMD_FILTER);
  assign coef_acc = in_acc && (cmd == CMD_COEF);

  // sample enters the chain as Q16.8
  always_comb begin
    link_in[0].valid = flt_acc;
    link_in[0].sat   = 1'b0;
    link_in[0].x     = {sample, {SIG_FRAC{1'b0}}};
  end

  // section chain
  logic [CMP_W-1:0] idx_ext;
  assign idx_ext = CMP_W'(coef_index);

  for (genvar k = 0; k < SECTIONS; k++) begin : g_sec
    coef_wr_t         wr;
    logic [CMP_W-1:0] rel;

    assign rel      = idx_ext - CMP_W'(NCOEF * k);
    assign wr.we    = coef_acc && (idx_ext >= CMP_W'(NCOEF * k))
                      && (idx_ext < CMP_W'(NCOEF * k + NCOEF));
    assign wr.slot  = coef_slot_e'(rel[2:0]);
    assign wr.value = coef_value;

    ibq_section_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .link_i (link_in[k]),
      .wr_i   (wr),
      .gain_i (gain_q),
      .link_o (link_out[k])
    );

    assign out_valids[k] = link_out[k].valid;

    // forward to the next cell only while it is active
    if (k + 1 < SECTIONS) begin : g_fwd
      always_comb begin
        link_in[k+1]       = link_out[k];
        link_in[k+1].valid = link_out[k].valid && (CNT_W'(k + 1) < n_eff);
      end
    end
  end

  assign done_link = link_out[last_idx];
  assign done      = done_link.valid;

  always_comb begin
    fin     = rnd_sat_out(done_link.x);
    fin.sat = fin.sat | done_link.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (flt_acc) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  // output register plus skid: a new result parks in the skid while the
  // previous one is still stalled
  logic     m_valid_q;
  out_res_t m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q    <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (done) begin
      if (!m_valid_q || m_axis_tready) begin
        m_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (m_valid_q && m_axis_tready) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      if (!m_valid_q || m_axis_tready) begin
        m_q <= fin;
      end else begin
        skid_q <= fin;
      end
    end else if (m_valid_q && m_axis_tready && skid_valid_q) begin
      m_q <= skid_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_q.val;
  assign m_axis_tuser  = m_q.sat;

  // checks
  `IBQ_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, m_valid_q, "skid holds data while output is empty")
  `IBQ_ASSERT_IMP(a_done_when_busy, clk_i, rst_ni, done, busy_q, "section result without a request in flight")
  `IBQ_ASSERT_IMP(a_one_cell_out, clk_i, rst_ni, 1'b1, $onehot0(out_valids), "more than one section cell finished at once")
  `IBQ_ASSERT_NXT(a_done_to_out, clk_i, rst_ni, done, m_axis_tvalid, "finished sample did not reach the output")

endmodule

[src/ibq_section_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ibq_section_cell
// One direct-form-I biquad section with gain, four pipeline stages.
// ---------------------------------------------------------------------------
module ibq_section_cell
  import ibq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  link_t                    link_i,
  input  coef_wr_t                 wr_i,
  input  logic signed [COEF_W-1:0] gain_i,
  output link_t                    link_o
);

  logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
  logic signed [SIG_W-1:0]  xd0_q, xd1_q, yd0_q, yd1_q;

  logic                     p_valid_q, s_valid_q, g_valid_q;
  logic                     p_sat_q, s_sat_q, g_sat_q;
  logic signed [PROD_W-1:0] p0_q, p1_q, p2_q, p3_q, p4_q;
  logic signed [SIG_W-1:0]  y_q;
  logic signed [PROD_W-1:0] g_q;
  logic                     out_valid_q, out_sat_q;
  logic signed [SIG_W-1:0]  out_x_q;

  logic signed [ACC_W-1:0]  acc;
  sig_res_t                 y_res, x_res;

  assign acc = ACC_W'(p0_q) + ACC_W'(p1_q) + ACC_W'(p2_q) - ACC_W'(p3_q) - ACC_W'(p4_q);
  assign y_res = rnd_sat_sig(acc);
  assign x_res = rnd_sat_sig(ACC_W'(g_q));

  // control, coefficients and delays
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= '0; b1_q <= '0; b2_q <= '0; a1_q <= '0; a2_q <= '0;
      xd0_q <= '0; xd1_q <= '0; yd0_q <= '0; yd1_q <= '0;
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        unique case (wr_i.slot)
          SLOT_B0: b0_q <= wr_i.value;
          SLOT_B1: b1_q <= wr_i.value;
          SLOT_B2: b2_q <= wr_i.value;
          SLOT_A1: a1_q <= wr_i.value;
          SLOT_A2: a2_q <= wr_i.value;
          default: ;
        endcase
      end
      if (link_i.valid) begin
        xd1_q <= xd0_q;
        xd0_q <= link_i.x;
      end
      if (p_valid_q) begin
        yd1_q <= yd0_q;
        yd0_q <= y_res.val;
      end
      p_valid_q   <= link_i.valid;
      s_valid_q   <= p_valid_q;
      g_valid_q   <= s_valid_q;
      out_valid_q <= g_valid_q;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (link_i.valid) begin
      p0_q    <= b0_q * link_i.x;
      p1_q    <= b1_q * xd0_q;
      p2_q    <= b2_q * xd1_q;
      p3_q    <= a1_q * yd0_q;
      p4_q    <= a2_q * yd1_q;
      p_sat_q <= link_i.sat;
    end
    if (p_valid_q) begin
      y_q     <= y_res.val;
      s_sat_q <= p_sat_q | y_res.sat;
    end
    if (s_valid_q) begin
      g_q     <= y_q * gain_i;
      g_sat_q <= s_sat_q;
    end
    if (g_valid_q) begin
      out_x_q   <= x_res.val;
      out_sat_q <= g_sat_q | x_res.sat;
    end
  end

  assign link_o = '{valid: out_valid_q, sat: out_sat_q, x: out_x_q};

endmodule
